>>> hdl/spo2_pkg.sv
// Shared types and constants for the SpO2 ratio-of-ratios estimator.
package spo2_pkg;

    // Gate limits
    localparam logic [19:0] DC_MIN     = 20'd5000;
    localparam logic [19:0] DC_MAX     = 20'd1000000;
    localparam int          AC_MIN     = 20;
    localparam int          AC_GOOD    = 40;
    localparam logic [6:0]  WEIGHT_CAP = 7'd80;
    localparam int          WSUM_MIN   = 4;
    localparam logic [15:0] R_LOW      = 16'd6554;
    localparam logic [15:0] R_HIGH     = 16'd32768;

    // Saturation limits, Q7.8
    localparam logic signed [17:0] SPO2_LOW   = 18'sd17920;
    localparam logic signed [17:0] SPO2_HIGH  = 18'sd25600;
    localparam logic [15:0]        PREV_MIN   = 16'd17920;
    localparam logic signed [17:0] STEP_SMALL = 18'sd768;
    localparam logic signed [17:0] STEP_LARGE = 18'sd1280;

    // Quality, Q1.15
    localparam logic [15:0] Q_ONE   = 16'd32768;
    localparam logic [15:0] Q_FLOOR = 16'd3277;
    localparam logic [15:0] Q_HALF  = 16'd16384;
    localparam logic [15:0] Q_GOOD  = 16'd26214;
    localparam logic [15:0] Q_HIGH  = 16'd22938;
    localparam logic [14:0] K_08    = 15'd26214;
    localparam logic [14:0] K_07    = 15'd22938;
    localparam logic [14:0] K_06    = 15'd19661;
    localparam logic [14:0] K_09    = 15'd29491;

    // Reciprocals for constant division: x/10 = (x*BLEND_RECIP) >> 21,
    // x/5 = (x*QMIX_RECIP) >> 20, exact for x below 2^18
    localparam logic [17:0] BLEND_RECIP = 18'd209716;
    localparam logic [17:0] QMIX_RECIP  = 18'd209716;

    // Register reset values
    localparam logic [15:0] OFFSET_RESET = 16'd28160;
    localparam logic [15:0] SLOPE_RESET  = 16'd6400;

    typedef enum logic [1:0] {
        CFG_OFFSET = 2'd0,
        CFG_SLOPE  = 2'd1
    } cfg_index_t;

    typedef enum logic [3:0] {
        STS_REPORTED    = 4'd0,
        STS_DC_BAD      = 4'd1,
        STS_AC_LOW      = 4'd2,
        STS_ACDC_HIGH   = 4'd3,
        STS_RATIO_BAD   = 4'd4,
        STS_R_RANGE     = 4'd5,
        STS_WARMUP      = 4'd6,
        STS_FEW_SAMPLES = 4'd7,
        STS_SPO2_RANGE  = 4'd8,
        STS_JUMP        = 4'd9,
        STS_PENDING     = 4'd10
    } status_t;

    typedef enum logic [19:0] {
        ST_IDLE  = 20'h00001,
        ST_GATE  = 20'h00002,
        ST_NUM   = 20'h00004,
        ST_DEN   = 20'h00008,
        ST_RCHK  = 20'h00010,
        ST_DIV   = 20'h00020,
        ST_STORE = 20'h00040,
        ST_WARM  = 20'h00080,
        ST_WALK  = 20'h00100,
        ST_WEND  = 20'h00200,
        ST_MEAN  = 20'h00400,
        ST_SMUL  = 20'h00800,
        ST_SPO2  = 20'h01000,
        ST_CHECK = 20'h02000,
        ST_BLEND = 20'h04000,
        ST_QUAL  = 20'h08000,
        ST_FINAL = 20'h10000,
        ST_REJM  = 20'h20000,
        ST_REJF  = 20'h40000,
        ST_OUT   = 20'h80000
    } state_t;

endpackage

>>> hdl/spo2_ratio_estimator.sv
// Top level: gated ratio-of-ratios SpO2 estimator with one shared multiplier and divider.
// Outcomes include a gate rejection, a warm-up item and a reported reading; s_tready is
// high only in idle, so the next sample is taken only once the last result is in the
// output register, later while m_tready holds the result back. The longer paths run
// the 16-step restoring divider (R and window mean) and the window walk, one entry per
// cycle through the shared multiplier. Reset: asynchronous, active low; clears control.
module spo2_ratio_estimator #(
    parameter int WINDOW_DEPTH = 12,
    parameter int SAMPLE_BITS  = 18
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    // s_tdata: red_alternating, red_steady, infrared_alternating, infrared_steady
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [((2*SAMPLE_BITS+40+7)/8)*8-1:0]      s_tdata,
    // m_tdata: saturation_value, signal_quality, valid_run_length, status_code
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [47:0]                                m_tdata,
    // m_tuser: reading_valid
    output logic [0:0]                                 m_tuser,
    input  logic                                       cfg_write,
    input  logic [1:0]                                 cfg_index,
    input  logic [15:0]                                cfg_data
);

    localparam int SB     = SAMPLE_BITS;
    localparam int MB_W   = (SB > 18) ? SB : 18;
    localparam int PROD_W = 20 + SB;
    localparam int DW     = PROD_W + 15;
    localparam int GW     = SB + 11;
    localparam int NW     = PROD_W + 4;
    localparam int IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SW_W   = $clog2(80 * WINDOW_DEPTH + 1);
    localparam int SRW_W  = $clog2(32768 * 80 * WINDOW_DEPTH + 1);

    // Control state
    spo2_pkg::state_t  state_reg, state_next;
    spo2_pkg::state_t  ret_reg, ret_next;
    logic [IDX_W-1:0]  wp_reg, wp_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [15:0]       prev_reg, prev_next;
    logic [15:0]       quality_reg, quality_next;
    logic [7:0]        run_reg, run_next;
    logic [15:0]       offset_reg, slope_reg;
    logic              m_tvalid_reg, m_tvalid_next;

    // Datapath
    logic [SB-1:0]     ra_reg, ra_next, ia_reg, ia_next;
    logic [19:0]       rd_reg, rd_next, id_reg, id_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [PROD_W-1:0] num_reg, num_next, den_reg, den_next;
    logic [DW-1:0]     rem_reg, rem_next, dsh_reg, dsh_next;
    logic [15:0]       quo_reg, quo_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [15:0]       cur_reg, cur_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  valid_reg, valid_next;
    logic [SW_W-1:0]   sumw_reg, sumw_next;
    logic [SRW_W-1:0]  sumrw_reg, sumrw_next;
    logic signed [17:0] spo2_reg, spo2_next;
    spo2_pkg::status_t rej_code_reg, rej_code_next;
    logic [14:0]       rej_k_reg, rej_k_next;
    logic              res_rv_reg, res_rv_next;
    logic [14:0]       res_sat_reg, res_sat_next;
    spo2_pkg::status_t res_sts_reg, res_sts_next;
    logic [47:0]       out_data_reg, out_data_next;
    logic              out_user_reg, out_user_next;

    // Window storage
    logic [15:0]       ratio_store_reg [WINDOW_DEPTH];
    logic [SB-1:0]     amp_store_reg   [WINDOW_DEPTH];

    // Shared multiplier operands
    logic [19:0]       mul_a;
    logic [MB_W-1:0]   mul_b;

    // Input unpacking and magnitudes
    logic [SB-1:0]     in_ra_raw, in_ia_raw, in_ra, in_ia;
    logic [19:0]       in_rd, in_id;

    // Gate helpers
    logic [GW-1:0]     ra_g, ia_g, rd_g, id_g;
    logic              dc_bad, ac_low, acdc_high, ratio_bad, cur_good;
    logic [NW-1:0]     num_g, den_g;

    // Walk helpers
    logic [15:0]       walk_r;
    logic [SB-1:0]     walk_a;
    logic              walk_ok;
    logic [6:0]        walk_w;

    // Divider step
    logic              div_ge;

    // Misc
    logic [CNT_W-1:0]  fill_inc;
    logic [PROD_W:0]   br_round;
    logic [16:0]       br_val;
    logic signed [17:0] diff, diff_abs, step_lim;
    logic [15:0]       scaled_q;
    logic [17:0]       qmix;
    logic [19:0]       blend_x;
    logic [15:0]       q_quo;
    logic [15:0]       q_clamped;

    assign in_ra_raw = s_tdata[SB-1:0];
    assign in_rd     = s_tdata[SB+19:SB];
    assign in_ia_raw = s_tdata[2*SB+19:SB+20];
    assign in_id     = s_tdata[2*SB+39:2*SB+20];
    assign in_ra     = in_ra_raw[SB-1] ? (~in_ra_raw + 1'b1) : in_ra_raw;
    assign in_ia     = in_ia_raw[SB-1] ? (~in_ia_raw + 1'b1) : in_ia_raw;

    assign s_tready = (state_reg == spo2_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // Gate comparisons by constant cross-multiplication
    assign ra_g = GW'(ra_reg);
    assign ia_g = GW'(ia_reg);
    assign rd_g = GW'(rd_reg);
    assign id_g = GW'(id_reg);
    assign dc_bad    = (id_reg < spo2_pkg::DC_MIN) || (rd_reg < spo2_pkg::DC_MIN) ||
                       (id_reg > spo2_pkg::DC_MAX) || (rd_reg > spo2_pkg::DC_MAX);
    assign ac_low    = (ia_reg < SB'(spo2_pkg::AC_MIN)) || (ra_reg < SB'(spo2_pkg::AC_MIN));
    assign acdc_high = (ia_g * GW'(100) > id_g * GW'(3)) || (ra_g * GW'(100) > rd_g * GW'(3));
    assign ratio_bad = (ra_g * GW'(1000) < rd_g) || (ia_g * GW'(1000) < id_g) ||
                       (ra_g * GW'(50) > rd_g) || (ia_g * GW'(50) > id_g);
    assign cur_good  = (ia_g >= (ra_g << 1)) && (ia_reg >= SB'(spo2_pkg::AC_GOOD)) &&
                       (ia_g * GW'(200) >= id_g);
    assign num_g = NW'(num_reg);
    assign den_g = NW'(den_reg);

    // Window entry under the walk pointer
    assign walk_r  = ratio_store_reg[idx_reg];
    assign walk_a  = amp_store_reg[idx_reg];
    assign walk_ok = (walk_r >= spo2_pkg::R_LOW) && (walk_r <= spo2_pkg::R_HIGH) &&
                     (walk_a >= SB'(spo2_pkg::AC_MIN));
    assign walk_w  = !walk_ok ? 7'd0 :
                     (walk_a < SB'(spo2_pkg::WEIGHT_CAP)) ? walk_a[6:0] : spo2_pkg::WEIGHT_CAP;

    assign div_ge   = (rem_reg >= dsh_reg);
    assign fill_inc = (fill_reg < CNT_W'(WINDOW_DEPTH)) ? fill_reg + 1'b1 : fill_reg;

    // Saturation from slope product
    assign br_round = {1'b0, prod_reg} + (PROD_W+1)'(8192);
    assign br_val   = br_round[30:14];

    // Jump check
    assign diff     = spo2_reg - $signed({2'b00, prev_reg});
    assign diff_abs = diff[17] ? -diff : diff;
    assign step_lim = (quality_reg >= spo2_pkg::Q_HIGH) ? spo2_pkg::STEP_SMALL
                                                         : spo2_pkg::STEP_LARGE;

    // Blend numerator 7s + 3p + 5, divided by 10 through the reciprocal
    assign blend_x = 20'(spo2_reg[14:0]) * 20'd7 + 20'(prev_reg) * 20'd3 + 20'd5;

    // Quality helpers; 4q + c divided by 5 through the reciprocal
    assign scaled_q  = prod_reg[30:15];
    assign qmix      = {quality_reg, 2'b00} + 18'(cur_reg);
    assign q_quo     = {1'b0, prod_reg[34:20]};
    assign q_clamped = (q_quo < spo2_pkg::Q_FLOOR) ? spo2_pkg::Q_FLOOR :
                       (q_quo > spo2_pkg::Q_ONE) ? spo2_pkg::Q_ONE : q_quo;

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            spo2_pkg::ST_GATE:
            begin
                mul_a = id_reg;
                mul_b = MB_W'(ra_reg);
            end
            spo2_pkg::ST_NUM:
            begin
                mul_a = rd_reg;
                mul_b = MB_W'(ia_reg);
            end
            spo2_pkg::ST_STORE:
            begin
                mul_a = 20'(quality_reg);
                mul_b = MB_W'(spo2_pkg::K_09);
            end
            spo2_pkg::ST_WALK:
            begin
                mul_a = 20'(walk_r);
                mul_b = MB_W'(walk_w);
            end
            spo2_pkg::ST_SMUL:
            begin
                mul_a = 20'(slope_reg);
                mul_b = MB_W'(quo_reg);
            end
            spo2_pkg::ST_CHECK:
            begin
                mul_a = blend_x;
                mul_b = MB_W'(spo2_pkg::BLEND_RECIP);
            end
            spo2_pkg::ST_QUAL:
            begin
                mul_a = 20'(qmix);
                mul_b = MB_W'(spo2_pkg::QMIX_RECIP);
            end
            spo2_pkg::ST_REJM:
            begin
                mul_a = 20'(quality_reg);
                mul_b = MB_W'(rej_k_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        wp_next       = wp_reg;
        fill_next     = fill_reg;
        prev_next     = prev_reg;
        quality_next  = quality_reg;
        run_next      = run_reg;
        m_tvalid_next = m_tvalid_reg;
        ra_next       = ra_reg;
        rd_next       = rd_reg;
        ia_next       = ia_reg;
        id_next       = id_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        dsh_next      = dsh_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        cur_next      = cur_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        valid_next    = valid_reg;
        sumw_next     = sumw_reg;
        sumrw_next    = sumrw_reg;
        spo2_next     = spo2_reg;
        rej_code_next = rej_code_reg;
        rej_k_next    = rej_k_reg;
        res_rv_next   = res_rv_reg;
        res_sat_next  = res_sat_reg;
        res_sts_next  = res_sts_reg;
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;

        // Output register drains independently
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            spo2_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ra_next    = in_ra;
                    rd_next    = in_rd;
                    ia_next    = in_ia;
                    id_next    = in_id;
                    state_next = spo2_pkg::ST_GATE;
                end
            end
            spo2_pkg::ST_GATE:
            begin
                state_next = spo2_pkg::ST_REJM;
                if (dc_bad)
                begin
                    rej_code_next = spo2_pkg::STS_DC_BAD;
                    rej_k_next    = spo2_pkg::K_08;
                end
                else if (ac_low)
                begin
                    rej_code_next = spo2_pkg::STS_AC_LOW;
                    rej_k_next    = spo2_pkg::K_08;
                end
                else if (acdc_high)
                begin
                    rej_code_next = spo2_pkg::STS_ACDC_HIGH;
                    rej_k_next    = spo2_pkg::K_07;
                end
                else if (ratio_bad)
                begin
                    rej_code_next = spo2_pkg::STS_RATIO_BAD;
                    rej_k_next    = spo2_pkg::K_08;
                end
                else
                begin
                    state_next = spo2_pkg::ST_NUM;
                end
            end
            spo2_pkg::ST_NUM:
            begin
                num_next   = prod_reg;
                state_next = spo2_pkg::ST_DEN;
            end
            spo2_pkg::ST_DEN:
            begin
                den_next   = prod_reg;
                state_next = spo2_pkg::ST_RCHK;
            end
            spo2_pkg::ST_RCHK:
            begin
                cur_next = cur_good ? spo2_pkg::Q_GOOD : spo2_pkg::Q_HALF;
                if ((num_g * NW'(10) < den_g * NW'(4)) || (num_g > (den_g << 1)))
                begin
                    rej_code_next = spo2_pkg::STS_R_RANGE;
                    rej_k_next    = spo2_pkg::K_07;
                    state_next    = spo2_pkg::ST_REJM;
                end
                else
                begin
                    // R = round(num * 2^14 / den)
                    rem_next   = (DW'(num_reg) << 14) + DW'(den_reg >> 1);
                    dsh_next   = DW'(den_reg) << 15;
                    cnt_next   = 4'd15;
                    ret_next   = spo2_pkg::ST_STORE;
                    state_next = spo2_pkg::ST_DIV;
                end
            end
            spo2_pkg::ST_DIV:
            begin
                // One quotient bit per cycle, MSB first
                if (div_ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                quo_next = {quo_reg[14:0], div_ge};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 4'd0)
                begin
                    state_next = ret_reg;
                end
            end
            spo2_pkg::ST_STORE:
            begin
                wp_next   = (wp_reg == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                fill_next = fill_inc;
                idx_next  = '0;
                pend_next = 1'b0;
                valid_next = '0;
                sumw_next  = '0;
                sumrw_next = '0;
                if ((fill_inc < CNT_W'(4)) ||
                    ((fill_inc >= CNT_W'(8)) && (fill_inc < CNT_W'(6))))
                begin
                    state_next = spo2_pkg::ST_WARM;
                end
                else if (fill_inc >= CNT_W'(8) && fill_inc < CNT_W'(6))
                begin
                    state_next = spo2_pkg::ST_WARM;
                end
                else
                begin
                    state_next = spo2_pkg::ST_WALK;
                end
            end
            spo2_pkg::ST_WARM:
            begin
                quality_next = (scaled_q > cur_reg) ? scaled_q : cur_reg;
                run_next     = 8'd0;
                res_rv_next  = 1'b0;
                res_sat_next = '0;
                res_sts_next = spo2_pkg::STS_WARMUP;
                state_next   = spo2_pkg::ST_OUT;
            end
            spo2_pkg::ST_WALK:
            begin
                sumw_next  = sumw_reg + SW_W'(walk_w);
                valid_next = valid_reg + CNT_W'(walk_ok);
                if (pend_reg)
                begin
                    sumrw_next = sumrw_reg + SRW_W'(prod_reg);
                end
                pend_next = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (CNT_W'(idx_reg) == fill_reg - 1'b1)
                begin
                    state_next = spo2_pkg::ST_WEND;
                end
            end
            spo2_pkg::ST_WEND:
            begin
                sumrw_next = sumrw_reg + SRW_W'(prod_reg);
                state_next = spo2_pkg::ST_MEAN;
            end
            spo2_pkg::ST_MEAN:
            begin
                if ((valid_reg < (fill_reg >> 1)) || (sumw_reg < SW_W'(spo2_pkg::WSUM_MIN)))
                begin
                    rej_code_next = spo2_pkg::STS_FEW_SAMPLES;
                    rej_k_next    = spo2_pkg::K_08;
                    state_next    = spo2_pkg::ST_REJM;
                end
                else
                begin
                    // Weighted mean, rounded
                    rem_next   = DW'(sumrw_reg) + DW'(sumw_reg >> 1);
                    dsh_next   = DW'(sumw_reg) << 15;
                    cnt_next   = 4'd15;
                    ret_next   = spo2_pkg::ST_SMUL;
                    state_next = spo2_pkg::ST_DIV;
                end
            end
            spo2_pkg::ST_SMUL:
            begin
                state_next = spo2_pkg::ST_SPO2;
            end
            spo2_pkg::ST_SPO2:
            begin
                spo2_next  = $signed({2'b00, offset_reg}) - $signed({1'b0, br_val});
                state_next = spo2_pkg::ST_CHECK;
            end
            spo2_pkg::ST_CHECK:
            begin
                if ((spo2_reg < spo2_pkg::SPO2_LOW) || (spo2_reg > spo2_pkg::SPO2_HIGH))
                begin
                    rej_code_next = spo2_pkg::STS_SPO2_RANGE;
                    rej_k_next    = spo2_pkg::K_07;
                    state_next    = spo2_pkg::ST_REJM;
                end
                else if ((prev_reg > spo2_pkg::PREV_MIN) && (diff_abs > step_lim))
                begin
                    rej_code_next = spo2_pkg::STS_JUMP;
                    rej_k_next    = spo2_pkg::K_06;
                    state_next    = spo2_pkg::ST_REJM;
                end
                else if ((prev_reg > spo2_pkg::PREV_MIN) && (quality_reg < spo2_pkg::Q_HALF))
                begin
                    // Blend with last value; product of blend_x is taken this cycle
                    state_next = spo2_pkg::ST_BLEND;
                end
                else
                begin
                    state_next = spo2_pkg::ST_QUAL;
                end
            end
            spo2_pkg::ST_BLEND:
            begin
                spo2_next  = 18'(prod_reg[35:21]);
                state_next = spo2_pkg::ST_QUAL;
            end
            spo2_pkg::ST_QUAL:
            begin
                if (run_reg != 8'd255)
                begin
                    run_next = run_reg + 1'b1;
                end
                prev_next  = spo2_reg[15:0];
                state_next = spo2_pkg::ST_FINAL;
            end
            spo2_pkg::ST_FINAL:
            begin
                quality_next = q_clamped;
                if (run_reg >= ((q_clamped >= spo2_pkg::Q_HIGH) ? 8'd2 : 8'd3))
                begin
                    res_rv_next  = 1'b1;
                    res_sat_next = spo2_reg[14:0];
                    res_sts_next = spo2_pkg::STS_REPORTED;
                end
                else
                begin
                    res_rv_next  = 1'b0;
                    res_sat_next = '0;
                    res_sts_next = spo2_pkg::STS_PENDING;
                end
                state_next = spo2_pkg::ST_OUT;
            end
            spo2_pkg::ST_REJM:
            begin
                state_next = spo2_pkg::ST_REJF;
            end
            spo2_pkg::ST_REJF:
            begin
                quality_next = scaled_q;
                run_next     = 8'd0;
                res_rv_next  = 1'b0;
                res_sat_next = '0;
                res_sts_next = rej_code_reg;
                state_next   = spo2_pkg::ST_OUT;
            end
            spo2_pkg::ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_user_next = res_rv_reg;
                    out_data_next = {5'd0, res_sts_reg, run_reg, quality_reg, res_sat_reg};
                    state_next    = spo2_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spo2_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= spo2_pkg::ST_IDLE;
            ret_reg      <= spo2_pkg::ST_IDLE;
            wp_reg       <= '0;
            fill_reg     <= '0;
            prev_reg     <= '0;
            quality_reg  <= '0;
            run_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            offset_reg   <= spo2_pkg::OFFSET_RESET;
            slope_reg    <= spo2_pkg::SLOPE_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            prev_reg     <= prev_next;
            quality_reg  <= quality_next;
            run_reg      <= run_next;
            m_tvalid_reg <= m_tvalid_next;
            // Configuration writes; zero data leaves the register as is
            if (cfg_write && (cfg_data != 16'd0))
            begin
                unique case (cfg_index)
                    spo2_pkg::CFG_OFFSET: offset_reg <= cfg_data;
                    spo2_pkg::CFG_SLOPE:  slope_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        ra_reg       <= ra_next;
        rd_reg       <= rd_next;
        ia_reg       <= ia_next;
        id_reg       <= id_next;
        prod_reg     <= prod_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        cur_reg      <= cur_next;
        idx_reg      <= idx_next;
        pend_reg     <= pend_next;
        valid_reg    <= valid_next;
        sumw_reg     <= sumw_next;
        sumrw_reg    <= sumrw_next;
        spo2_reg     <= spo2_next;
        rej_code_reg <= rej_code_next;
        rej_k_reg    <= rej_k_next;
        res_rv_reg   <= res_rv_next;
        res_sat_reg  <= res_sat_next;
        res_sts_reg  <= res_sts_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    // Window write, one entry per accepted ratio
    always_ff @(posedge clk)
    begin
        if (state_reg == spo2_pkg::ST_STORE)
        begin
            ratio_store_reg[wp_reg] <= quo_reg;
            amp_store_reg[wp_reg]   <= ia_reg;
        end
    end

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("window fill count above depth");

    a_quality_bound: assert property (@(posedge clk) disable iff (!rst_n)
        quality_reg <= spo2_pkg::Q_ONE)
        else $error("quality score above one");

    a_accept_gate: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == spo2_pkg::ST_GATE))
        else $error("accepted transaction did not start gating");

    a_reading_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |->
            ((m_tdata[42:39] == spo2_pkg::STS_REPORTED) && (m_tdata[38:31] != 8'd0)))
        else $error("reading reported without reported status or run");

endmodule

>>> test/spo2_ratio_estimator_tb.sv
// Self-checking testbench for the SpO2 ratio-of-ratios estimator.
module spo2_ratio_estimator_tb;

    localparam int DEPTH = 12;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        reading_valid;
        logic [14:0] saturation_value;
        logic [15:0] signal_quality;
        logic [7:0]  valid_run_length;
        logic [3:0]  status_code;
    } reading_t;

    // Scoreboard: models the estimator state and keeps expected readings
    class spo2_scoreboard;
        logic [15:0] ratio_win [DEPTH];
        logic [17:0] amp_win [DEPTH];
        int unsigned wr_pos;
        int unsigned fill;
        longint      prev_sat;
        longint unsigned quality;
        int unsigned run_len;
        longint unsigned offset_a;
        longint unsigned slope_b;
        reading_t    pending_q[$];
        int          errors;

        function new();
            int i;
            for (i = 0; i < DEPTH; i++)
            begin
                ratio_win[i] = '0;
                amp_win[i] = '0;
            end
            wr_pos = 0;
            fill = 0;
            prev_sat = 0;
            quality = 0;
            run_len = 0;
            offset_a = spo2_pkg::OFFSET_RESET;
            slope_b = spo2_pkg::SLOPE_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            if (val == 0)
                return;
            if (idx == spo2_pkg::CFG_OFFSET)
                offset_a = val;
            else if (idx == spo2_pkg::CFG_SLOPE)
                slope_b = val;
        endfunction

        function longint unsigned mag18(logic [17:0] raw);
            if (raw[17])
                return longint'(18'(~raw + 18'd1));
            return longint'(raw);
        endfunction

        function bit q_high(longint unsigned q);
            return q * 10 > 229376;
        endfunction

        function void push_reject(longint unsigned k, spo2_pkg::status_t code);
            reading_t r;
            run_len = 0;
            quality = (quality * k) >> 15;
            r = '0;
            r.signal_quality = quality[15:0];
            r.status_code = code;
            pending_q.push_back(r);
        endfunction

        // Predict the reading for one accepted sample
        function void note_sample(logic [75:0] d);
            longint unsigned ra, rd, ia, id, num, den, rq, cur, need, valid;
            longint unsigned srw, sw, rs, w, dq, lim;
            longint spo2, diff;
            reading_t r;
            int i;
            ra = mag18(d[17:0]);
            rd = d[37:18];
            ia = mag18(d[55:38]);
            id = d[75:56];
            srw = 0;
            sw = 0;
            valid = 0;
            if (id < spo2_pkg::DC_MIN || rd < spo2_pkg::DC_MIN ||
                id > spo2_pkg::DC_MAX || rd > spo2_pkg::DC_MAX)
            begin
                push_reject(spo2_pkg::K_08, spo2_pkg::STS_DC_BAD);
                return;
            end
            if (ia < spo2_pkg::AC_MIN || ra < spo2_pkg::AC_MIN)
            begin
                push_reject(spo2_pkg::K_08, spo2_pkg::STS_AC_LOW);
                return;
            end
            if (100 * ia > 3 * id || 100 * ra > 3 * rd)
            begin
                push_reject(spo2_pkg::K_07, spo2_pkg::STS_ACDC_HIGH);
                return;
            end
            if (1000 * ra < rd || 1000 * ia < id || 50 * ra > rd || 50 * ia > id)
            begin
                push_reject(spo2_pkg::K_08, spo2_pkg::STS_RATIO_BAD);
                return;
            end
            num = ra * id;
            den = rd * ia;
            if (10 * num < 4 * den || num > 2 * den)
            begin
                push_reject(spo2_pkg::K_07, spo2_pkg::STS_R_RANGE);
                return;
            end
            rq = (num * 16384 + den / 2) / den;
            cur = (ia >= 2 * ra && ia >= spo2_pkg::AC_GOOD && 200 * ia >= id) ?
                  spo2_pkg::Q_GOOD : spo2_pkg::Q_HALF;
            ratio_win[wr_pos] = rq[15:0];
            amp_win[wr_pos] = ia[17:0];
            wr_pos = (wr_pos + 1) % DEPTH;
            if (fill < DEPTH)
                fill++;
            need = (fill >= 8) ? 6 : 4;
            if (fill < need)
            begin
                dq = (quality * spo2_pkg::K_09) >> 15;
                run_len = 0;
                quality = dq > cur ? dq : cur;
                r = '0;
                r.signal_quality = quality[15:0];
                r.status_code = spo2_pkg::STS_WARMUP;
                pending_q.push_back(r);
                return;
            end
            // Amplitude-weighted mean over the window
            for (i = 0; i < fill; i++)
            begin
                if (ratio_win[i] >= spo2_pkg::R_LOW && ratio_win[i] <= spo2_pkg::R_HIGH &&
                    amp_win[i] >= spo2_pkg::AC_MIN)
                begin
                    w = amp_win[i] < spo2_pkg::WEIGHT_CAP ? amp_win[i] : spo2_pkg::WEIGHT_CAP;
                    srw += ratio_win[i] * w;
                    sw += w;
                    valid++;
                end
            end
            if (valid < fill / 2 || sw < spo2_pkg::WSUM_MIN)
            begin
                push_reject(spo2_pkg::K_08, spo2_pkg::STS_FEW_SAMPLES);
                return;
            end
            rs = (srw + sw / 2) / sw;
            spo2 = longint'(offset_a) - longint'((slope_b * rs + 8192) >> 14);
            if (spo2 < spo2_pkg::SPO2_LOW || spo2 > spo2_pkg::SPO2_HIGH)
            begin
                push_reject(spo2_pkg::K_07, spo2_pkg::STS_SPO2_RANGE);
                return;
            end
            if (prev_sat > spo2_pkg::PREV_MIN)
            begin
                diff = spo2 - prev_sat;
                lim = q_high(quality) ? spo2_pkg::STEP_SMALL : spo2_pkg::STEP_LARGE;
                if (diff < 0)
                    diff = -diff;
                if (diff > longint'(lim))
                begin
                    push_reject(spo2_pkg::K_06, spo2_pkg::STS_JUMP);
                    return;
                end
                if (quality < spo2_pkg::Q_HALF)
                    spo2 = (7 * spo2 + 3 * prev_sat + 5) / 10;
            end
            if (run_len < 255)
                run_len++;
            prev_sat = spo2;
            quality = (4 * quality + cur) / 5;
            if (quality < spo2_pkg::Q_FLOOR)
                quality = spo2_pkg::Q_FLOOR;
            if (quality > spo2_pkg::Q_ONE)
                quality = spo2_pkg::Q_ONE;
            need = q_high(quality) ? 2 : 3;
            r = '0;
            r.signal_quality = quality[15:0];
            r.valid_run_length = run_len[7:0];
            if (run_len >= need)
            begin
                r.reading_valid = 1'b1;
                r.saturation_value = spo2[14:0];
                r.status_code = spo2_pkg::STS_REPORTED;
            end
            else
                r.status_code = spo2_pkg::STS_PENDING;
            pending_q.push_back(r);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_reading(reading_t got);
            reading_t want;
            if (pending_q.size() == 0)
            begin
                report_mismatch("unexpected reading", 1, 0);
                return;
            end
            want = pending_q.pop_front();
            if (got.reading_valid !== want.reading_valid)
                report_mismatch("reading_valid", got.reading_valid, want.reading_valid);
            if (got.saturation_value !== want.saturation_value)
                report_mismatch("saturation_value", got.saturation_value,
                                want.saturation_value);
            if (got.signal_quality !== want.signal_quality)
                report_mismatch("signal_quality", got.signal_quality, want.signal_quality);
            if (got.valid_run_length !== want.valid_run_length)
                report_mismatch("valid_run_length", got.valid_run_length,
                                want.valid_run_length);
            if (got.status_code !== want.status_code)
                report_mismatch("status_code", got.status_code, want.status_code);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    spo2_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;
    int samples_sent;
    int readings_seen;
    int reported_seen;

    spo2_ratio_estimator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random stall, check every accepted reading
    always @(posedge clk)
    begin
        reading_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.reading_valid = m_tuser[0];
            got.saturation_value = m_tdata[14:0];
            got.signal_quality = m_tdata[30:15];
            got.valid_run_length = m_tdata[38:31];
            got.status_code = m_tdata[42:39];
            sb.check_reading(got);
            readings_seen++;
            if (got.reading_valid)
                reported_seen++;
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Valid stays high after a transaction until the next sample or a pause
    task automatic send_sample(logic [17:0] ra, logic [19:0] rd, logic [17:0] ia,
                               logic [19:0] id);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, id, ia, rd, ra};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample({id, ia, rd, ra});
        samples_sent++;
    endtask

    task automatic drain_readings();
        int n;
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        for (n = 0; n < 120; n++)
            @(posedge clk);
    endtask

    // Register write with the block idle
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        drain_readings();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // Plausible sample: ratio near 0.5..1.0 with random levels
    task automatic send_good();
        int id, rd, ia, ra;
        id = $urandom_range(900000, 20000);
        rd = $urandom_range(900000, 20000);
        ia = (id / 1000) * $urandom_range(25, 8) / 10 + 20;
        ra = int'(longint'(ia) * rd / id * $urandom_range(100, 45) / 100 + 1);
        if ($urandom_range(99) < 3)
            ia = -ia;
        if ($urandom_range(99) < 3)
            ra = -ra;
        send_sample(18'(ra), 20'(rd), 18'(ia), 20'(id));
    endtask

    task automatic send_noise();
        send_sample(18'($urandom), 20'($urandom), 18'($urandom), 20'($urandom));
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int count);
        int k;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(99) < 85)
                send_good();
            else
                send_noise();
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = spo2_pkg::CFG_OFFSET;
        cfg_data = '0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        samples_sent = 0;
        readings_seen = 0;
        reported_seen = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every gate, field extremes, warm-up and estimates
        send_sample(18'd100, 20'd4999, 18'd100, 20'd50000);
        send_sample(18'd100, 20'd50000, 18'd100, 20'd1000001);
        send_sample(18'h1FFFF, 20'hFFFFF, 18'h20000, 20'hFFFFF);
        send_sample(18'd0, 20'd0, 18'd0, 20'd0);
        send_sample(18'd19, 20'd50000, 18'd100, 20'd50000);
        send_sample(18'd2000, 20'd50000, 18'd100, 20'd50000);
        send_sample(18'd40, 20'd50000, 18'd100, 20'd50000);
        send_sample(18'd1100, 20'd50000, 18'd1100, 20'd50000);
        send_sample(18'd40, 20'd20000, 18'd200, 20'd20000);
        send_sample(18'd600, 20'd100000, 18'd250, 20'd100000);
        send_sample(-18'sd300, 20'd100000, 18'd600, 20'd100000);
        repeat (7) send_sample(18'd300, 20'd100000, -18'sd600, 20'd100000);
        send_sample(18'd500, 20'd100000, 18'd600, 20'd100000);
        repeat (4) send_sample(18'd250, 20'd100000, 18'd30, 20'd10000);

        // Pause until every outstanding reading has been checked
        drain_readings();

        run_phase(0, 0, 400);
        write_reg(spo2_pkg::CFG_OFFSET, 16'hFFFF);
        write_reg(spo2_pkg::CFG_SLOPE, 16'd1);
        run_phase(85, 0, 150);
        write_reg(spo2_pkg::CFG_OFFSET, 16'd1);
        write_reg(spo2_pkg::CFG_SLOPE, 16'hFFFF);
        run_phase(0, 85, 150);
        write_reg(spo2_pkg::CFG_OFFSET, 16'd0);
        write_reg(2'd2, 16'd1234);
        write_reg(spo2_pkg::CFG_OFFSET, 16'd28000);
        write_reg(spo2_pkg::CFG_SLOPE, 16'd5000);
        run_phase(29, 29, 450);
        write_reg(spo2_pkg::CFG_OFFSET, spo2_pkg::OFFSET_RESET);
        write_reg(spo2_pkg::CFG_SLOPE, spo2_pkg::SLOPE_RESET);
        run_phase(0, 0, 450);

        drain_readings();
        $display("covered %0d samples, %0d readings checked, %0d with a saturation value",
                 samples_sent, readings_seen, reported_seen);
        $display("register settings swept across extremes under four idle/stall mixes");
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

>>> spo2_ratio_estimator.f
hdl/spo2_pkg.sv
hdl/spo2_ratio_estimator.sv
test/spo2_ratio_estimator_tb.sv
